// ===== rtl/tctf_pkg.sv =====
// Shared types and constants for the tunnel client table forwarder.
`default_nettype none

package tctf_pkg;

    // One client table entry
    typedef struct packed {
        logic        valid;
        logic [31:0] host;
        logic [15:0] port;
    } entry_t;

    // One result item, without the last marker
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] host;
        logic [15:0] port;
        logic        conn;
    } result_t;

    // Input commands
    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_FWD   = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    // Header values
    localparam logic [31:0] BCAST_HOST = 32'hffff_ffff;
    localparam logic [15:0] REG_SOCKET = 16'h0002;
    localparam logic [31:0] REG_HOST   = 32'h0000_0000;

    // Forward copies per packet
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

endpackage

`default_nettype wire

// ===== rtl/tctf_cell.sv =====
// One slot of the client table; a link in the rotating chain.
`default_nettype none

module tctf_cell
    import tctf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   clear,      // drop the connected flag
    input  wire logic   shift,      // take the neighbor's entry
    input  wire entry_t next_entry, // entry from the neighbor
    output entry_t      entry
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] host_reg;
    logic [31:0] host_next;
    logic [15:0] port_reg;
    logic [15:0] port_next;

    // Next entry: shift from neighbor, or clear flag only
    always_comb
    begin
        valid_next = valid_reg;
        host_next  = host_reg;
        port_next  = port_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            valid_next = next_entry.valid;
            host_next  = next_entry.host;
            port_next  = next_entry.port;
        end
    end

    // Connected flag is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Address payload, undefined until written
    always_ff @(posedge clk)
    begin
        host_reg <= host_next;
        port_reg <= port_next;
    end

    assign entry.valid = valid_reg;
    assign entry.host  = host_reg;
    assign entry.port  = port_reg;

endmodule

`default_nettype wire

// ===== rtl/tunnel_client_table_forwarder.sv =====
// Top level of the tunnel client table forwarder.
// The client table is a ring of TABLE_SLOTS cells that rotates by one slot
// per cycle while an item is processed; slot 0 sits at the head and is the
// only one examined, and a full turn puts every slot back in place. A packet
// that walks the table (forward or registration) or an in range query makes
// one full turn before its final result; a registration on a full table with
// no matching source then makes a second turn as a forward walk. Clear,
// unknown commands, bad lengths and out of range queries skip the walk and
// go straight to the final result. The rotation pauses while a result waits
// on a stalled output. A new input is taken once the previous item's final
// result sits in the output register.
`default_nettype none

module tunnel_client_table_forwarder
    import tctf_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS      = 16,
    parameter int unsigned MAX_PACKET_BYTES = 1424
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Input transactions
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pkt_bytes, dest_socket, dest_host, dest_port, src_host, src_port,
    // sender_host, sender_port, slot_index, 2 bits zero fill
    input  wire logic [183:0] s_axis_tdata,
    // command
    input  wire logic [1:0]   s_axis_tuser,
    // Result transactions
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // target_host, target_port, entry_connected, 7 bits zero fill
    output logic [55:0]       m_axis_tdata,
    // kind
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int unsigned SW = $clog2(TABLE_SLOTS);
    localparam logic [SW-1:0]   LAST_STEP = SW'(TABLE_SLOTS - 1);
    localparam logic [16:0]     MAX_LEN   = 17'(MAX_PACKET_BYTES);
    localparam logic [6:0]      SLOTS_7   = 7'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Walk modes
    localparam logic [1:0] MODE_REG   = 2'd0;
    localparam logic [1:0] MODE_FWD   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Input field unpacking
    logic [15:0] in_len;
    logic [15:0] in_dsock;
    logic [31:0] in_dhost;
    logic [15:0] in_dport;
    logic [31:0] in_shost;
    logic [15:0] in_sport;
    logic [31:0] in_rhost;
    logic [15:0] in_rport;
    logic [5:0]  in_idx;

    assign in_len   = s_axis_tdata[15:0];
    assign in_dsock = s_axis_tdata[31:16];
    assign in_dhost = s_axis_tdata[63:32];
    assign in_dport = s_axis_tdata[79:64];
    assign in_shost = s_axis_tdata[111:80];
    assign in_sport = s_axis_tdata[127:112];
    assign in_rhost = s_axis_tdata[159:128];
    assign in_rport = s_axis_tdata[175:160];
    assign in_idx   = s_axis_tdata[181:176];

    // Control registers
    logic [1:0]       state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [SW-1:0]    step_reg, step_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers
    result_t          pend_reg, pend_next;
    result_t          out_res_reg, out_res_next;
    logic             out_last_reg, out_last_next;
    logic [31:0]      dhost_reg, dhost_next;
    logic [15:0]      dport_reg, dport_next;
    logic [31:0]      shost_reg, shost_next;
    logic [15:0]      sport_reg, sport_next;
    logic [31:0]      rhost_reg, rhost_next;
    logic [15:0]      rport_reg, rport_next;
    logic [SW-1:0]    idx_reg, idx_next;
    logic             bcast_reg, bcast_next;

    // Chain of table cells
    entry_t cell_out [TABLE_SLOTS];
    entry_t cell_in  [TABLE_SLOTS];
    entry_t head;
    entry_t tail_in;
    logic   chain_shift;
    logic   chain_clear;

    genvar k;
    generate
        for (k = 0; k < TABLE_SLOTS; k++)
        begin : g_cell
            if (k == TABLE_SLOTS - 1)
            begin : g_tail
                assign cell_in[k] = tail_in;
            end
            else
            begin : g_link
                assign cell_in[k] = cell_out[k + 1];
            end

            tctf_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (chain_clear),
                .shift      (chain_shift),
                .next_entry (cell_in[k]),
                .entry      (cell_out[k])
            );
        end
    endgenerate

    assign head = cell_out[0];

    // Head slot evaluation
    logic    accept;
    logic    out_free;
    logic    len_ok;
    logic    is_reg_pkt;
    logic    idx_in_range;
    logic    src_match;
    logic    dst_match;
    logic    reg_take;
    logic    fwd_hit;
    logic    q_hit;
    logic    new_res;
    result_t new_val;
    logic    stall;
    logic    advance;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign chain_clear   = accept && (s_axis_tuser == CMD_CLEAR);

    assign len_ok       = (in_len != 16'd0) && ({1'b0, in_len} <= MAX_LEN);
    assign is_reg_pkt   = (in_dsock == REG_SOCKET) && (in_dhost == REG_HOST);
    assign idx_in_range = ({1'b0, in_idx} < SLOTS_7);

    assign src_match = (head.host == shost_reg) && (head.port == sport_reg);
    assign dst_match = bcast_reg ? !src_match
                                 : ((head.host == dhost_reg) && (head.port == dport_reg));

    assign reg_take = (mode_reg == MODE_REG) && !found_reg && (!head.valid || src_match);
    assign fwd_hit  = (mode_reg == MODE_FWD) && head.valid && dst_match && (cnt_reg < CNT_MAX);
    assign q_hit    = (mode_reg == MODE_QUERY) && (step_reg == idx_reg);
    assign new_res  = reg_take || fwd_hit || q_hit;

    // Result found at the head this step
    always_comb
    begin
        new_val.kind = KIND_FWD;
        new_val.host = head.host;
        new_val.port = head.port;
        new_val.conn = 1'b0;
        if (reg_take)
        begin
            new_val.kind = KIND_ACK;
            new_val.host = rhost_reg;
            new_val.port = rport_reg;
        end
        else if (q_hit)
        begin
            new_val.kind = KIND_QUERY;
            new_val.conn = head.valid;
        end
    end

    assign stall       = new_res && pend_valid_reg && !out_free;
    assign advance     = (state_reg == ST_WALK) && !stall;
    assign chain_shift = advance;

    // Entry written back at the tail; registration updates it
    always_comb
    begin
        tail_in = head;
        if (reg_take)
        begin
            tail_in.valid = 1'b1;
            tail_in.host  = head.valid ? head.host : rhost_reg;
            tail_in.port  = rport_reg;
        end
    end

    // Sequencer and result staging
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        dhost_next      = dhost_reg;
        dport_next      = dport_reg;
        shost_next      = shost_reg;
        sport_next      = sport_reg;
        rhost_next      = rhost_reg;
        rport_next      = rport_reg;
        idx_next        = idx_reg;
        bcast_next      = bcast_reg;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = m_axis_tready ? 1'b0 : out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dhost_next      = in_dhost;
                    dport_next      = in_dport;
                    shost_next      = in_shost;
                    sport_next      = in_sport;
                    rhost_next      = in_rhost;
                    rport_next      = in_rport;
                    idx_next        = in_idx[SW-1:0];
                    bcast_next      = (in_dhost == BCAST_HOST);
                    step_next       = '0;
                    found_next      = 1'b0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_DONE;
                    if (s_axis_tuser == CMD_PACKET && len_ok)
                    begin
                        mode_next  = is_reg_pkt ? MODE_REG : MODE_FWD;
                        state_next = ST_WALK;
                    end
                    else if (s_axis_tuser == CMD_QUERY)
                    begin
                        if (idx_in_range)
                        begin
                            mode_next  = MODE_QUERY;
                            state_next = ST_WALK;
                        end
                        else
                        begin
                            pend_valid_next = 1'b1;
                            pend_next.kind  = KIND_QUERY;
                            pend_next.host  = '0;
                            pend_next.port  = '0;
                            pend_next.conn  = 1'b0;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                if (advance)
                begin
                    step_next = step_reg + 1'b1;
                    if (new_res)
                    begin
                        // Older result goes out, newer one waits for its last flag
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_res_next   = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = new_val;
                    end
                    if (reg_take)
                    begin
                        found_next = 1'b1;
                    end
                    if (fwd_hit)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (step_reg == LAST_STEP)
                    begin
                        // Full table with no match: forward instead
                        if (mode_reg == MODE_REG && !found_reg && !reg_take)
                        begin
                            mode_next = MODE_FWD;
                            step_next = '0;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_res_next = pend_reg;
                    end
                    else
                    begin
                        out_res_next.kind = KIND_NONE;
                        out_res_next.host = '0;
                        out_res_next.port = '0;
                        out_res_next.conn = 1'b0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_FWD;
            step_reg       <= '0;
            found_reg      <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            step_reg       <= step_next;
            found_reg      <= found_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
        dhost_reg    <= dhost_next;
        dport_reg    <= dport_next;
        shost_reg    <= shost_next;
        sport_reg    <= sport_next;
        rhost_reg    <= rhost_next;
        rport_reg    <= rport_next;
        idx_reg      <= idx_next;
        bcast_reg    <= bcast_next;
    end

    // Output port packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_res_reg.conn, out_res_reg.port, out_res_reg.host};

endmodule

`default_nettype wire

// ===== dv/tunnel_client_table_forwarder_tb.sv =====
// Testbench for the tunnel client table forwarder: directed and random traffic with a scoreboard.
`default_nettype none

module tunnel_client_table_forwarder_tb
    import tctf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_SLOTS      = 16;
    localparam int unsigned MAX_PACKET_BYTES = 1424;
    // Command value the block does not decode
    localparam logic [1:0]  CMD_UNKNOWN      = 2'd3;
    // Longest item: registration on a full table
    localparam int unsigned SETTLE_CYCLES    = 2 * TABLE_SLOTS + 8;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned PHASE_ITEMS      = 106;

    // Input transaction layout, first field in the lowest bits
    typedef struct packed {
        logic [1:0]  fill;
        logic [5:0]  slot_index;
        logic [15:0] sender_port;
        logic [31:0] sender_host;
        logic [15:0] src_port;
        logic [31:0] src_host;
        logic [15:0] dest_port;
        logic [31:0] dest_host;
        logic [15:0] dest_socket;
        logic [15:0] pkt_bytes;
    } request_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } reply_t;

    logic         clk;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = CMD_PACKET;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // Shadow of the client table and which slots have ever been written
    entry_t       client_tbl [TABLE_SLOTS];
    bit           slot_written [TABLE_SLOTS];
    reply_t       pending_replies [$];

    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  mismatches     = 0;
    int unsigned  items_sent     = 0;
    int unsigned  quiet_cycles   = 0;
    int unsigned  n_ack = 0, n_fwd = 0, n_none = 0, n_query = 0;

    tunnel_client_table_forwarder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        foreach (client_tbl[i])
        begin
            client_tbl[i]   = '0;
            slot_written[i] = 1'b0;
        end
    end

    // Expected replies for one accepted transaction; updates the shadow table
    function automatic void predict_replies(input logic [1:0] cmd, input request_t rq);
        result_t outs [$];
        logic    hit;
        bit      done;
        done = 1'b0;
        case (cmd)
            CMD_CLEAR:
            begin
                foreach (client_tbl[i])
                    client_tbl[i].valid = 1'b0;
            end
            CMD_QUERY:
            begin
                if (rq.slot_index < TABLE_SLOTS)
                    outs.push_back('{KIND_QUERY, client_tbl[rq.slot_index].host,
                                     client_tbl[rq.slot_index].port,
                                     client_tbl[rq.slot_index].valid});
                else
                    outs.push_back('{KIND_QUERY, 32'h0, 16'h0, 1'b0});
            end
            CMD_PACKET:
            begin
                if (rq.pkt_bytes != 0 && rq.pkt_bytes <= MAX_PACKET_BYTES)
                begin
                    // Registration: first free slot, or port update on source match
                    if (rq.dest_socket == REG_SOCKET && rq.dest_host == REG_HOST)
                    begin
                        for (int i = 0; i < TABLE_SLOTS && !done; i++)
                        begin
                            if (!client_tbl[i].valid)
                            begin
                                client_tbl[i]   = '{1'b1, rq.sender_host, rq.sender_port};
                                slot_written[i] = 1'b1;
                                done = 1'b1;
                            end
                            else if (client_tbl[i].host == rq.src_host &&
                                     client_tbl[i].port == rq.src_port)
                            begin
                                client_tbl[i].port = rq.sender_port;
                                done = 1'b1;
                            end
                        end
                        if (done)
                            outs.push_back('{KIND_ACK, rq.sender_host, rq.sender_port, 1'b0});
                    end
                    // Forwarding, also taken by a registration on a full table
                    if (!done)
                    begin
                        for (int i = 0; i < TABLE_SLOTS && outs.size() < MAX_RESULTS; i++)
                        begin
                            if (client_tbl[i].valid)
                            begin
                                if (rq.dest_host == BCAST_HOST)
                                    hit = (client_tbl[i].host != rq.src_host) ||
                                          (client_tbl[i].port != rq.src_port);
                                else
                                    hit = (client_tbl[i].host == rq.dest_host) &&
                                          (client_tbl[i].port == rq.dest_port);
                                if (hit)
                                    outs.push_back('{KIND_FWD, client_tbl[i].host,
                                                     client_tbl[i].port, 1'b0});
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (outs.size() == 0)
            outs.push_back('{KIND_NONE, 32'h0, 16'h0, 1'b0});
        foreach (outs[k])
            pending_replies.push_back('{outs[k], logic'(k == outs.size() - 1)});
    endfunction

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    // Result receiver: random stalls, then compare against the oldest expectation
    always @(posedge clk)
    begin
        reply_t want;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (m_axis_tvalid && m_axis_tready)
        begin
            case (m_axis_tuser)
                KIND_ACK:   n_ack++;
                KIND_FWD:   n_fwd++;
                KIND_NONE:  n_none++;
                KIND_QUERY: n_query++;
                default: ;
            endcase
            if (pending_replies.size() == 0)
                flag_mismatch("result with nothing pending (kind)", '0, 64'(m_axis_tuser));
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tuser !== want.res.kind)
                    flag_mismatch("kind", 64'(want.res.kind), 64'(m_axis_tuser));
                if (m_axis_tdata[31:0] !== want.res.host)
                    flag_mismatch("target_host", 64'(want.res.host), 64'(m_axis_tdata[31:0]));
                if (m_axis_tdata[47:32] !== want.res.port)
                    flag_mismatch("target_port", 64'(want.res.port), 64'(m_axis_tdata[47:32]));
                if (m_axis_tdata[48] !== want.res.conn)
                    flag_mismatch("entry_connected", 64'(want.res.conn), 64'(m_axis_tdata[48]));
                if (m_axis_tlast !== want.last)
                    flag_mismatch("last", 64'(want.last), 64'(m_axis_tlast));
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, pending_replies.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Drive one input transaction and record its expected replies on acceptance
    task automatic send_item(input logic [1:0] cmd, input request_t rq);
        request_t item;
        item      = rq;
        item.fill = '0;
        // Never ask about a slot that was never written
        if (cmd == CMD_QUERY && item.slot_index < TABLE_SLOTS && !slot_written[item.slot_index])
            item.slot_index = 6'(TABLE_SLOTS + $urandom_range(63 - TABLE_SLOTS));
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tdata  <= item;
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_replies(cmd, item);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic request_t make_req(input logic [15:0] len, input logic [15:0] dsock,
                                          input logic [31:0] dhost, input logic [15:0] dport,
                                          input logic [31:0] shost, input logic [15:0] sport,
                                          input logic [31:0] rhost, input logic [15:0] rport,
                                          input logic [5:0] idx);
        return '{2'b00, idx, rport, rhost, sport, shost, dport, dhost, dsock, len};
    endfunction

    function automatic request_t reg_req(input logic [31:0] shost, input logic [15:0] sport,
                                         input logic [31:0] rhost, input logic [15:0] rport);
        return make_req(16'd64, REG_SOCKET, REG_HOST, 16'h0, shost, sport, rhost, rport, 6'd0);
    endfunction

    function automatic logic [31:0] pick_host();
        case ($urandom_range(7))
            0:          return 32'h0;
            1:          return BCAST_HOST;
            2, 3, 4, 5: return 32'h0a00_0000 + $urandom_range(5);
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(5))
            0:       return 16'h0;
            1:       return 16'hffff;
            2, 3:    return 16'(16'd1000 + $urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    // Returns a connected slot, or -1 when the chosen slot is free
    function automatic int live_slot();
        int i;
        i = $urandom_range(TABLE_SLOTS - 1);
        return client_tbl[i].valid ? i : -1;
    endfunction

    // Out-of-range queries, bad lengths and unknown commands on an empty table
    task automatic test_rejects();
        send_item(CMD_QUERY, make_req(16'd1, '0, '0, '0, '0, '0, '0, '0, 6'd16));
        send_item(CMD_QUERY, make_req(16'd1, '0, '0, '0, '0, '0, '0, '0, 6'd63));
        send_item(CMD_PACKET, make_req(16'd0, REG_SOCKET, REG_HOST, '0,
                                       '0, '0, 32'h0a00_0001, 16'd1000, '0));
        send_item(CMD_PACKET, make_req(16'(MAX_PACKET_BYTES + 1), REG_SOCKET, REG_HOST, '0,
                                       '0, '0, 32'h0a00_0001, 16'd1000, '0));
        send_item(CMD_PACKET, make_req(16'hffff, 16'hffff, BCAST_HOST, 16'hffff,
                                       32'hffff_ffff, 16'hffff, 32'hffff_ffff, 16'hffff, 6'h3f));
        send_item(CMD_UNKNOWN, reg_req('0, '0, 32'h0a00_0001, 16'd1000));
    endtask

    // New clients at the length limits, a port update, a query
    task automatic test_registration();
        request_t rq;
        rq = reg_req(32'h1234_5678, 16'd7, 32'h0a00_0001, 16'd1000);
        rq.pkt_bytes = 16'd1;
        send_item(CMD_PACKET, rq);
        rq = reg_req(32'h1234_5678, 16'd7, 32'hffff_ffff, 16'hffff);
        rq.pkt_bytes = 16'(MAX_PACKET_BYTES);
        send_item(CMD_PACKET, rq);
        send_item(CMD_PACKET, reg_req(32'h1234_5678, 16'd7, 32'h0, 16'h0));
        // Reported source matches slot 0: its port moves to the sender port
        send_item(CMD_PACKET, reg_req(32'h0a00_0001, 16'd1000, 32'h0a00_0001, 16'd2000));
        send_item(CMD_QUERY, make_req('0, '0, '0, '0, '0, '0, '0, '0, 6'd0));
    endtask

    task automatic test_forwarding();
        send_item(CMD_PACKET, make_req(16'd100, 16'd5, 32'h0a00_0001, 16'd2000,
                                       32'h0, 16'h0, 32'h0, 16'h0, '0));
        // Stale port: no match
        send_item(CMD_PACKET, make_req(16'd100, 16'd5, 32'h0a00_0001, 16'd1000,
                                       32'h0, 16'h1, 32'h0, 16'h0, '0));
        // Broadcast skips the reported source
        send_item(CMD_PACKET, make_req(16'd100, 16'hffff, BCAST_HOST, 16'd9,
                                       32'h0a00_0001, 16'd2000, 32'h0, 16'h0, '0));
        send_item(CMD_PACKET, make_req(16'd100, 16'd0, BCAST_HOST, 16'd9,
                                       32'h5555_aaaa, 16'h5a5a, 32'h0, 16'h0, '0));
    endtask

    task automatic test_clear();
        send_item(CMD_CLEAR, make_req('0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_item(CMD_QUERY, make_req('0, '0, '0, '0, '0, '0, '0, '0, 6'd1));
        send_item(CMD_PACKET, make_req(16'd100, 16'd0, BCAST_HOST, 16'd9,
                                       32'h5555_aaaa, 16'h5a5a, 32'h0, 16'h0, '0));
        send_item(CMD_PACKET, reg_req(32'h0, 16'h0, 32'h0a00_0002, 16'd3000));
    endtask

    // Fill every slot; a registration then falls through to forwarding
    task automatic test_full_table();
        for (int i = 1; i < TABLE_SLOTS; i++)
        begin
            if (i == 9)
                send_item(CMD_PACKET, reg_req(32'hdead_0000, 16'd1, 32'h0, 16'h1234));
            else
                send_item(CMD_PACKET, reg_req(32'hdead_0000, 16'd1,
                                              32'h0b00_0000 + i, 16'(i * 7)));
        end
        send_item(CMD_PACKET, make_req(16'd64, REG_SOCKET, REG_HOST, 16'h1234,
                                       32'h0c00_0000, 16'd1, 32'h0c00_0000, 16'd1, '0));
        send_item(CMD_PACKET, make_req(16'd64, 16'd7, BCAST_HOST, 16'd0,
                                       32'h0, 16'h1234, 32'h0, 16'h0, '0));
        send_item(CMD_PACKET, make_req(16'd64, 16'd7, BCAST_HOST, 16'd0,
                                       32'h0c00_0000, 16'd1, 32'h0, 16'h0, '0));
    endtask

    // Mostly well-formed traffic against the live table, with some noise
    task automatic test_random_traffic(input int unsigned send_idle, input int unsigned recv_stall,
                                       input int unsigned count);
        request_t    rq;
        logic [1:0]  cmd;
        int unsigned sel;
        int          s;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        repeat (count)
        begin
            rq  = make_req(16'($urandom_range(MAX_PACKET_BYTES, 1)), 16'($urandom), $urandom,
                           16'($urandom), $urandom, 16'($urandom), pick_host(), pick_port(),
                           6'($urandom));
            cmd = CMD_PACKET;
            sel = $urandom_range(99);
            s   = live_slot();
            if (sel < 35)
            begin
                rq.dest_socket = REG_SOCKET;
                rq.dest_host   = REG_HOST;
                if (s >= 0 && $urandom_range(1))
                begin
                    rq.src_host = client_tbl[s].host;
                    rq.src_port = client_tbl[s].port;
                end
                else
                begin
                    rq.src_host = pick_host();
                    rq.src_port = pick_port();
                end
            end
            else if (sel < 60)
            begin
                rq.dest_host = (s >= 0) ? client_tbl[s].host : pick_host();
                rq.dest_port = (s >= 0) ? client_tbl[s].port : pick_port();
            end
            else if (sel < 75)
            begin
                rq.dest_host = BCAST_HOST;
                rq.src_host  = (s >= 0) ? client_tbl[s].host : pick_host();
                rq.src_port  = (s >= 0) ? client_tbl[s].port : pick_port();
            end
            else if (sel < 80)
            begin
                rq.pkt_bytes   = $urandom_range(3) == 0 ? 16'd0
                               : 16'($urandom_range(16'hffff, MAX_PACKET_BYTES + 1));
                rq.dest_socket = $urandom_range(1) ? REG_SOCKET : rq.dest_socket;
                rq.dest_host   = $urandom_range(1) ? REG_HOST : rq.dest_host;
            end
            else if (sel < 83)
                cmd = CMD_CLEAR;
            else if (sel < 91)
                cmd = CMD_QUERY;
            else if (sel < 94)
                cmd = CMD_UNKNOWN;
            else
                rq.pkt_bytes = 16'($urandom);
            send_item(cmd, rq);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rejects();
        test_registration();
        test_forwarding();
        test_clear();
        test_full_table();

        test_random_traffic(0, 0, PHASE_ITEMS);
        test_random_traffic(87, 0, PHASE_ITEMS);
        // Sender holds off until every reply is back
        hold_until_drained();
        test_random_traffic(0, 87, PHASE_ITEMS);
        test_random_traffic(11, 11, PHASE_ITEMS);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d transactions over four idle/stall mixes, table fill, clear and overflow.",
                 items_sent);
        $display("Replies seen: %0d ack, %0d forward, %0d nothing sent, %0d query; %0d mismatches.",
                 n_ack, n_fwd, n_none, n_query, mismatches);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== tunnel_client_table_forwarder.f =====
rtl/tctf_pkg.sv
rtl/tctf_cell.sv
rtl/tunnel_client_table_forwarder.sv
dv/tunnel_client_table_forwarder_tb.sv
